// ===== rtl/hed_pkg.sv =====
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, character codes and helper functions for the entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

    // character codes
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;

    // code point handling
    localparam int CP_W = 17;
    localparam logic [CP_W-1:0] CP_2B_MIN = 17'h00080;
    localparam logic [CP_W-1:0] CP_3B_MIN = 17'h00800;
    localparam logic [CP_W-1:0] CP_SAT    = 17'h10000;
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [5:0] UTF_MASK  = 6'h3F;

    // output byte source
    typedef logic [2:0] emit_sel_t;
    localparam emit_sel_t EMIT_IN   = 3'd0;
    localparam emit_sel_t EMIT_AMP  = 3'd1;
    localparam emit_sel_t EMIT_SEMI = 3'd2;
    localparam emit_sel_t EMIT_HELD = 3'd3;
    localparam emit_sel_t EMIT_NAME = 3'd4;
    localparam emit_sel_t EMIT_UTF  = 3'd5;

    // source of the verbatim end index
    typedef logic [1:0] end_sel_t;
    localparam end_sel_t END_CNT  = 2'd0;
    localparam end_sel_t END_CNT1 = 2'd1;
    localparam end_sel_t END_WIN  = 2'd2;

    typedef struct packed {
        logic      in_ready;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_final;
        logic      hold_wr;
        logic      ovr_wr;
        logic      copy_wr;
        logic      open_ent;
        logic      close_ent;
        logic      ptr_clr;
        logic      ptr_inc;
        logic      parse_init;
        logic      cp_step;
        logic      end_load;
        end_sel_t  end_sel;
        logic      semi_set;
    } hed_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_amp;
        logic in_semi;
        logic in_last;
        logic in_entity;
        logic cnt_full;
        logic out_free;
        logic name_hit;
        logic is_num;
        logic digit_ok;
        logic utf_last;
        logic end_zero;
        logic semi;
        logic ptr_at_end;
        logic ptr_last;
        logic amp_here;
        logic amp_next;
        logic amp0;
    } hed_stat_t;

    // {valid, value} of one digit
    function automatic logic [4:0] digit_decode(input logic [7:0] c, input logic hex);
        logic [4:0] r;
        r = '0;
        if (c >= CH_0 && c <= CH_9)
            r = {1'b1, 4'(c - CH_0)};
        else if (hex && c >= CH_A_LO && c <= CH_F_LO)
            r = {1'b1, 4'(c - CH_A_LO + 8'd10)};
        else if (hex && c >= CH_A_UP && c <= CH_F_UP)
            r = {1'b1, 4'(c - CH_A_UP + 8'd10)};
        return r;
    endfunction

    function automatic logic [1:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [1:0] n;
        if (cp < CP_2B_MIN)
            n = 2'd1;
        else if (cp < CP_3B_MIN)
            n = 2'd2;
        else if (cp < CP_SAT)
            n = 2'd3;
        else
            n = 2'd1;
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] idx);
        logic [7:0] b;
        if (cp < CP_2B_MIN)
            b = cp[7:0];
        else if (cp < CP_3B_MIN)
            b = (idx == 2'd0) ? (UTF_LEAD2 | {3'b000, cp[10:6]})
                              : (UTF_CONT | {2'b00, cp[5:0] & UTF_MASK});
        else if (cp < CP_SAT)
        begin
            if (idx == 2'd0)
                b = UTF_LEAD3 | {4'b0000, cp[15:12]};
            else if (idx == 2'd1)
                b = UTF_CONT | {2'b00, cp[11:6] & UTF_MASK};
            else
                b = UTF_CONT | {2'b00, cp[5:0] & UTF_MASK};
        end
        else
            b = CH_QMARK;
        return b;
    endfunction

endpackage

// ===== rtl/hed_in_if.sv =====
// ----------------------------------------------------------------------------
// hed_in_if
// Input byte channel: valid/ready handshake with the text byte and end mark.
// ----------------------------------------------------------------------------
interface hed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

// ===== rtl/hed_out_if.sv =====
// ----------------------------------------------------------------------------
// hed_out_if
// Output byte channel: valid/ready handshake with decoded byte and end marks.
// ----------------------------------------------------------------------------
interface hed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_last;

    modport source (output valid, output out_byte, output run_last, output stream_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_last,
                    output ready);
endinterface

// ===== rtl/hed_ctrl.sv =====
// ----------------------------------------------------------------------------
// hed_ctrl
// Sequencer for the entity decoder: accepts bytes and steps the datapath.
// ----------------------------------------------------------------------------
module hed_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  hed_pkg::hed_stat_t stat,
    output hed_pkg::hed_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLASS = 4'd1;
    localparam logic [3:0] S_PARSE = 4'd2;
    localparam logic [3:0] S_UTF   = 4'd3;
    localparam logic [3:0] S_AMPV  = 4'd4;
    localparam logic [3:0] S_BODY  = 4'd5;
    localparam logic [3:0] S_SEMI  = 4'd6;
    localparam logic [3:0] S_AMPS  = 4'd7;
    localparam logic [3:0] S_SCAN  = 4'd8;
    localparam logic [3:0] S_COPY  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = stat.out_free;
                if (stat.in_valid && stat.out_free)
                begin
                    if (!stat.in_entity)
                    begin
                        if (!stat.in_amp)
                        begin
                            cmd.emit       = 1'b1;
                            cmd.emit_sel   = hed_pkg::EMIT_IN;
                            cmd.emit_final = 1'b1;
                        end
                        else if (stat.in_last)
                        begin
                            cmd.emit       = 1'b1;
                            cmd.emit_sel   = hed_pkg::EMIT_AMP;
                            cmd.emit_final = 1'b1;
                        end
                        else
                            cmd.open_ent = 1'b1;
                    end
                    else if (stat.in_semi)
                        state_next = S_CLASS;
                    else if (!stat.cnt_full)
                    begin
                        cmd.hold_wr = 1'b1;
                        if (stat.in_last)
                        begin
                            cmd.end_load = 1'b1;
                            cmd.end_sel  = hed_pkg::END_CNT1;
                            state_next   = S_AMPV;
                        end
                    end
                    else
                    begin
                        cmd.ovr_wr = 1'b1;
                        if (stat.in_last)
                        begin
                            cmd.end_load = 1'b1;
                            cmd.end_sel  = hed_pkg::END_WIN;
                            state_next   = S_AMPV;
                        end
                        else
                            state_next = S_AMPS;
                    end
                end
            end
            S_CLASS:
            begin
                if (stat.name_hit)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit       = 1'b1;
                        cmd.emit_sel   = hed_pkg::EMIT_NAME;
                        cmd.emit_final = 1'b1;
                        cmd.close_ent  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (stat.is_num)
                begin
                    cmd.parse_init = 1'b1;
                    state_next     = S_PARSE;
                end
                else
                begin
                    cmd.end_load = 1'b1;
                    cmd.end_sel  = hed_pkg::END_CNT;
                    cmd.semi_set = 1'b1;
                    state_next   = S_AMPV;
                end
            end
            S_PARSE:
            begin
                if (stat.digit_ok)
                begin
                    cmd.cp_step = 1'b1;
                    cmd.ptr_inc = 1'b1;
                end
                else
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = S_UTF;
                end
            end
            S_UTF:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = hed_pkg::EMIT_UTF;
                    cmd.emit_final = stat.utf_last;
                    cmd.ptr_inc    = 1'b1;
                    if (stat.utf_last)
                    begin
                        cmd.close_ent = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_AMPV:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = hed_pkg::EMIT_AMP;
                    cmd.ptr_clr  = 1'b1;
                    state_next   = stat.end_zero ? S_SEMI : S_BODY;
                end
            end
            S_BODY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = hed_pkg::EMIT_HELD;
                    cmd.emit_final = !stat.semi && stat.ptr_at_end;
                    cmd.ptr_inc    = 1'b1;
                    if (stat.ptr_at_end)
                    begin
                        if (stat.semi)
                            state_next = S_SEMI;
                        else
                        begin
                            cmd.close_ent = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                end
            end
            S_SEMI:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = hed_pkg::EMIT_SEMI;
                    cmd.emit_final = 1'b1;
                    cmd.close_ent  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_AMPS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = hed_pkg::EMIT_AMP;
                    cmd.emit_final = stat.amp0;
                    cmd.ptr_clr    = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.amp_here)
                begin
                    cmd.open_ent = 1'b1;
                    cmd.ptr_inc  = 1'b1;
                    state_next   = stat.ptr_last ? S_IDLE : S_COPY;
                end
                else if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = hed_pkg::EMIT_HELD;
                    cmd.emit_final = stat.amp_next;
                    cmd.ptr_inc    = 1'b1;
                    if (stat.ptr_last)
                    begin
                        cmd.close_ent = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_COPY:
            begin
                cmd.copy_wr = 1'b1;
                cmd.ptr_inc = 1'b1;
                if (stat.ptr_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/hed_datapath.sv =====
// ----------------------------------------------------------------------------
// hed_datapath
// Held-byte window, code point accumulator and output register.
// ----------------------------------------------------------------------------
module hed_datapath
#(
    parameter int ENTITY_WINDOW = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    hed_in_if.sink             in_ch,
    hed_out_if.source          out_ch,
    input  hed_pkg::hed_cmd_t  cmd,
    output hed_pkg::hed_stat_t stat
);

    localparam int CW = $clog2(ENTITY_WINDOW);
    localparam int EW = $clog2(ENTITY_WINDOW + 1);
    localparam int CPW = hed_pkg::CP_W;
    localparam logic [CW-1:0] IDX_LAST = CW'(ENTITY_WINDOW - 1);
    localparam logic [EW-1:0] END_WIN_VAL = EW'(ENTITY_WINDOW);

    logic [7:0]          held_reg [ENTITY_WINDOW];
    logic [CW-1:0]       held_cnt_reg, held_cnt_next;
    logic                in_entity_reg, in_entity_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [EW-1:0]       end_reg, end_next;
    logic                semi_reg, semi_next;
    logic [CPW-1:0]      cp_reg, cp_next;
    logic                base16_reg, base16_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                run_last_reg, run_last_next;
    logic                stream_last_reg, stream_last_next;

    logic                take;
    logic                out_free;
    logic                held_we;
    logic [CW-1:0]       held_wa;
    logic [7:0]          held_wd;
    logic [7:0]          rd_byte;
    logic [ENTITY_WINDOW-1:0] amp_vec;
    logic [ENTITY_WINDOW-1:0] amp_sh;
    logic [4:0]          cnt_ext;
    logic                hit_amp, hit_lt, hit_gt, hit_quot, hit_apos;
    logic [7:0]          name_char;
    logic                hex_ref;
    logic [4:0]          dig;
    logic [20:0]         cp_mul;
    logic [20:0]         cp_sum;
    logic [1:0]          utf_len;
    logic [7:0]          emit_byte;

    assign take      = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = cmd.in_ready;

    // held window: one write port, one read port at ptr
    assign held_we = cmd.hold_wr || cmd.ovr_wr || cmd.copy_wr;
    assign held_wa = cmd.ovr_wr ? IDX_LAST : held_cnt_reg;
    assign held_wd = cmd.copy_wr ? rd_byte : in_ch.in_byte;
    assign rd_byte = held_reg[ptr_reg];

    always_ff @(posedge clk)
    begin
        if (held_we)
            held_reg[held_wa] <= held_wd;
    end

    always_comb
    begin
        for (int i = 0; i < ENTITY_WINDOW; i++)
            amp_vec[i] = (held_reg[i] == hed_pkg::CH_AMP);
    end
    assign amp_sh = amp_vec >> ptr_reg;

    // named references
    assign cnt_ext  = 5'(held_cnt_reg);
    assign hit_amp  = (cnt_ext == 5'd3) && held_reg[0] == "a" && held_reg[1] == "m"
                      && held_reg[2] == "p";
    assign hit_lt   = (cnt_ext == 5'd2) && held_reg[0] == "l" && held_reg[1] == "t";
    assign hit_gt   = (cnt_ext == 5'd2) && held_reg[0] == "g" && held_reg[1] == "t";
    assign hit_quot = (cnt_ext == 5'd4) && held_reg[0] == "q" && held_reg[1] == "u"
                      && held_reg[2] == "o" && held_reg[3] == "t";
    assign hit_apos = (cnt_ext == 5'd4) && held_reg[0] == "a" && held_reg[1] == "p"
                      && held_reg[2] == "o" && held_reg[3] == "s";

    always_comb
    begin
        priority if (hit_amp)
            name_char = hed_pkg::CH_AMP;
        else if (hit_lt)
            name_char = hed_pkg::CH_LT;
        else if (hit_gt)
            name_char = hed_pkg::CH_GT;
        else if (hit_quot)
            name_char = hed_pkg::CH_QUOT;
        else
            name_char = hed_pkg::CH_APOS;
    end

    // numeric references
    assign hex_ref = (cnt_ext > 5'd1)
                     && (held_reg[1] == hed_pkg::CH_X_LO || held_reg[1] == hed_pkg::CH_X_UP);
    assign dig     = hed_pkg::digit_decode(rd_byte, base16_reg);
    assign cp_mul  = base16_reg ? {cp_reg, 4'b0000}
                                : (21'({cp_reg, 3'b000}) + 21'({cp_reg, 1'b0}));
    assign cp_sum  = cp_mul + 21'(dig[3:0]);
    assign utf_len = hed_pkg::utf8_len(cp_reg);

    always_comb
    begin
        unique case (cmd.emit_sel)
            hed_pkg::EMIT_IN:   emit_byte = in_ch.in_byte;
            hed_pkg::EMIT_AMP:  emit_byte = hed_pkg::CH_AMP;
            hed_pkg::EMIT_SEMI: emit_byte = hed_pkg::CH_SEMI;
            hed_pkg::EMIT_HELD: emit_byte = rd_byte;
            hed_pkg::EMIT_NAME: emit_byte = name_char;
            hed_pkg::EMIT_UTF:  emit_byte = hed_pkg::utf8_byte(cp_reg, ptr_reg[1:0]);
            default:            emit_byte = hed_pkg::CH_QMARK;
        endcase
    end

    always_comb
    begin
        held_cnt_next    = held_cnt_reg;
        in_entity_next   = in_entity_reg;
        ptr_next         = ptr_reg;
        end_next         = end_reg;
        semi_next        = semi_reg;
        cp_next          = cp_reg;
        base16_next      = base16_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        run_last_next    = run_last_reg;
        stream_last_next = stream_last_reg;

        if (cmd.close_ent)
        begin
            held_cnt_next  = '0;
            in_entity_next = 1'b0;
        end
        else if (cmd.open_ent)
        begin
            held_cnt_next  = '0;
            in_entity_next = 1'b1;
        end
        else if (cmd.hold_wr || cmd.copy_wr)
            held_cnt_next = held_cnt_reg + CW'(1);

        if (cmd.parse_init)
            ptr_next = hex_ref ? CW'(2) : CW'(1);
        else if (cmd.ptr_clr)
            ptr_next = '0;
        else if (cmd.ptr_inc && ptr_reg != IDX_LAST)
            ptr_next = ptr_reg + CW'(1);

        if (cmd.parse_init)
        begin
            cp_next     = '0;
            base16_next = hex_ref;
        end
        else if (cmd.cp_step)
            cp_next = (cp_sum > 21'(hed_pkg::CP_SAT)) ? hed_pkg::CP_SAT : cp_sum[CPW-1:0];

        if (cmd.end_load)
        begin
            semi_next = cmd.semi_set;
            unique case (cmd.end_sel)
                hed_pkg::END_CNT:  end_next = EW'(held_cnt_reg);
                hed_pkg::END_CNT1: end_next = EW'(held_cnt_reg) + EW'(1);
                hed_pkg::END_WIN:  end_next = END_WIN_VAL;
                default:           end_next = END_WIN_VAL;
            endcase
        end

        if (take)
            last_next = in_ch.last_in;

        if (cmd.emit)
        begin
            out_valid_next   = 1'b1;
            out_byte_next    = emit_byte;
            run_last_next    = cmd.emit_final;
            stream_last_next = cmd.emit_final && (take ? in_ch.last_in : last_reg);
        end
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg  <= '0;
            in_entity_reg <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_cnt_reg  <= held_cnt_next;
            in_entity_reg <= in_entity_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg         <= end_next;
        semi_reg        <= semi_next;
        cp_reg          <= cp_next;
        base16_reg      <= base16_next;
        last_reg        <= last_next;
        out_byte_reg    <= out_byte_next;
        run_last_reg    <= run_last_next;
        stream_last_reg <= stream_last_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.run_last    = run_last_reg;
    assign out_ch.stream_last = stream_last_reg;

    assign stat.in_valid   = in_ch.valid;
    assign stat.in_amp     = (in_ch.in_byte == hed_pkg::CH_AMP);
    assign stat.in_semi    = (in_ch.in_byte == hed_pkg::CH_SEMI);
    assign stat.in_last    = in_ch.last_in;
    assign stat.in_entity  = in_entity_reg;
    assign stat.cnt_full   = (held_cnt_reg == IDX_LAST);
    assign stat.out_free   = out_free;
    assign stat.name_hit   = hit_amp || hit_lt || hit_gt || hit_quot || hit_apos;
    assign stat.is_num     = (held_cnt_reg != '0) && (held_reg[0] == hed_pkg::CH_HASH);
    assign stat.digit_ok   = (ptr_reg < held_cnt_reg) && dig[4];
    assign stat.utf_last   = (ptr_reg == CW'(utf_len - 2'd1));
    assign stat.end_zero   = (end_reg == '0);
    assign stat.semi       = semi_reg;
    assign stat.ptr_at_end = ((EW'(ptr_reg) + EW'(1)) == end_reg);
    assign stat.ptr_last   = (ptr_reg == IDX_LAST);
    assign stat.amp_here   = (rd_byte == hed_pkg::CH_AMP);
    assign stat.amp_next   = (ptr_reg == IDX_LAST) || amp_sh[1];
    assign stat.amp0       = amp_vec[0];

    // the output register is only loaded when its beat is gone or leaving
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ch.ready))
        else $error("output register overwritten while holding a beat");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg <= IDX_LAST)
        else $error("held count beyond window");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_entity_reg |-> (held_cnt_reg == '0))
        else $error("held bytes left with no open entity");

    a_stream_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stream_last_reg) |-> run_last_reg)
        else $error("stream end marked on a beat that does not end its run");

endmodule

// ===== rtl/html_entity_decoder_top.sv =====
// ----------------------------------------------------------------------------
// html_entity_decoder_top
// Streaming HTML entity decoder with valid/ready byte channels.
// ----------------------------------------------------------------------------
// Text bytes enter on in_ch and decoded bytes leave on out_ch, one beat per
// byte. Ordinary bytes, an opening '&' and each byte held inside an open
// entity are taken at one per cycle while the output side keeps up. A ';'
// closing an entity leads to a classify state: a named reference emits its
// character, a numeric reference parses its digits up to the first non-digit
// and emits its code point (up to 3 bytes for UTF-8, 1 for '?'), and unknown
// text is emitted as '&', the held bytes and ';' (2 + held count bytes). A
// window overrun emits '&', then visits each of the ENTITY_WINDOW window
// bytes in turn: bytes ahead of a held '&' are emitted, that '&' opens a new
// entity and the bytes after it are moved down. With last_in set, an open
// entity is flushed as '&' plus the held bytes, one per cycle while the
// output side keeps up. During these sequences in_ch.ready is low; the
// single output register decides the pace whenever out_ch.ready drops.
// run_last marks the last beat caused by one input beat, stream_last that
// beat when the input carried last_in.
// ----------------------------------------------------------------------------
module html_entity_decoder_top
#(
    parameter int ENTITY_WINDOW = 10
)
(
    input  logic      clk,
    input  logic      rst_n,
    hed_in_if.sink    in_ch,
    hed_out_if.source out_ch
);

    // command and status between sequencer and datapath
    hed_pkg::hed_cmd_t  cmd;
    hed_pkg::hed_stat_t stat;

    // sequencer: idle intake, classify, digit parse, utf-8 out, verbatim
    // out, overrun rescan and window compaction
    hed_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: held window, code point accumulator, output register
    hed_datapath
    #(
        .ENTITY_WINDOW (ENTITY_WINDOW)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule
